### rtl/fswp_pkg.sv
// ----------------------------------------------------------------------------
// fswp_pkg
// Shared widths, reset values, codes and control types of the frame slack
// window predictor.
// ----------------------------------------------------------------------------
package fswp_pkg;

   // history depth default
   localparam int HISTORY_DEPTH_DEF = 32;

   // field widths
   localparam int TIME_W     = 48;
   localparam int SLACK_W    = 20;
   localparam int AVG_W      = 24;
   localparam int PRED_W     = 32;
   localparam int KIND_W     = 2;
   localparam int BUDGET_W   = 20;
   localparam int WCOUNT_W   = 2;
   localparam int WLEN_W     = 5;
   localparam int WEIGHT_W   = 18;
   localparam int BIAS_W     = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;

   // datapath widths of the multiply-accumulate unit
   localparam int SUM_W  = 25;
   localparam int PROD_W = 44;
   localparam int ACC_W  = 46;
   localparam int FRAC_W = 16;

   // longest moving sum
   localparam logic [WLEN_W-1:0] WLEN_MAX = 5'd16;

   // rounding constant of the Q16 product sum
   localparam logic signed [ACC_W-1:0] ACC_ROUND = 46'sd32768;

   // register reset values
   localparam logic [BUDGET_W-1:0]        BUDGET_RST = 20'd16667;
   localparam logic [WCOUNT_W-1:0]        WCOUNT_RST = 2'd3;
   localparam logic [WLEN_W-1:0]          WLEN_RST   = 5'd4;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT0_RST = 18'sd57238;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT1_RST = 18'sd7834;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT2_RST = -18'sd3738;
   localparam logic signed [BIAS_W-1:0]   BIAS_RST    = 21'sd11277;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BUDGET  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WCOUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WLEN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT2 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS    = 3'd6;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_FRAME_END = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PREDICT   = 2'd2;

   // control of the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic mul;
      logic acc;
   } mac_ctl_type;

endpackage

### rtl/fswp_history.sv
// ----------------------------------------------------------------------------
// fswp_history
// Slack history memory, one write and one registered read port. Entries that
// were never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module fswp_history
   import fswp_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int AW            = $clog2(HISTORY_DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [SLACK_W-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr,
   output logic [SLACK_W-1:0] rd_data
);

   logic [SLACK_W-1:0]       mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] valid_ff;
   logic [HISTORY_DEPTH-1:0] valid_in;
   logic [SLACK_W-1:0]       rd_data_ff;
   logic                     rd_valid_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // valid bits mark written entries
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // unwritten entries read as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### rtl/fswp_mac.sv
// ----------------------------------------------------------------------------
// fswp_mac
// Shared multiply-accumulate unit: one registered product of a moving sum and
// its Q16 weight, then one add into the accumulator.
// ----------------------------------------------------------------------------
module fswp_mac
   import fswp_pkg::*;
(
   input  logic                       clock,
   input  mac_ctl_type                ctl,
   input  logic [SUM_W-1:0]           sum,
   input  logic signed [WEIGHT_W-1:0] weight,
   output logic signed [ACC_W-1:0]    acc
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [SUM_W:0]    sum_s;

   assign sum_s = $signed({1'b0, sum});

   // product stage
   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff <= PROD_W'(sum_s * weight);
      end
   end

   // accumulator, cleared to the rounding constant
   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = ACC_ROUND;
      end else if (ctl.acc) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### rtl/frame_slack_window_predictor_unit.sv
// ----------------------------------------------------------------------------
// frame_slack_window_predictor_unit
// Frame timing tracker and slack window predictor with a sequenced datapath.
// ----------------------------------------------------------------------------
// One event is worked on at a time; req_stall stays high from the transfer of
// an event until its result is loaded into the output register. A predict
// sums count lags of length entries each, up to three lags of sixteen
// entries: the history memory gives one entry per cycle into the moving sum,
// the moving sum waits for its registered read to drain, and the single
// multiplier and accumulator weight each lag in turn.
// Kind 3 is taken and dropped with no result. A result is held in the output
// register while the output side stalls; the next event is still taken, but
// once it is finished it waits with req_stall high until that register is
// free. The history reads as zero after reset without any clearing pass.
// ----------------------------------------------------------------------------
module frame_slack_window_predictor_unit
   import fswp_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // event channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [TIME_W-1:0]        req_frame_begin_us,
   input  logic [TIME_W-1:0]        req_now_us,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SLACK_W-1:0]       rsp_slack_us,
   output logic [AVG_W-1:0]         rsp_avg_frame_us,
   output logic signed [PRED_W-1:0] rsp_prediction_us,
   output logic [KIND_W-1:0]        rsp_echo_kind,
   // register write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(HISTORY_DEPTH);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_FEND1  = 11'b000_0000_0010,
      S_FEND2  = 11'b000_0000_0100,
      S_QRY1   = 11'b000_0000_1000,
      S_QRY2   = 11'b000_0001_0000,
      S_PSTART = 11'b000_0010_0000,
      S_PSUM   = 11'b000_0100_0000,
      S_PMUL   = 11'b000_1000_0000,
      S_PACC   = 11'b001_0000_0000,
      S_PFIN   = 11'b010_0000_0000,
      S_DONE   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [BUDGET_W-1:0]        budget_ff, budget_in;
   logic [WCOUNT_W-1:0]        wcount_ff, wcount_in;
   logic [WLEN_W-1:0]          wlen_ff, wlen_in;
   logic signed [WEIGHT_W-1:0] weight_ff [3];
   logic signed [WEIGHT_W-1:0] weight_in [3];
   logic signed [BIAS_W-1:0]   bias_ff, bias_in;

   // block state
   logic [AW-1:0]      head_ff, head_in;
   logic [AVG_W-1:0]   avg_ff, avg_in;
   logic [SLACK_W-1:0] cur_slack_ff, cur_slack_in;
   logic [TIME_W-1:0]  last_end_ff, last_end_in;

   // captured event
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [TIME_W-1:0] begin_ff, begin_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // working registers
   logic [AVG_W-1:0]         ft_ff, ft_in;
   logic [SLACK_W:0]         elapsed_ff, elapsed_in;
   logic [1:0]               lag_ff, lag_in;
   logic [AW-1:0]            ptr_ff, ptr_in;
   logic [WLEN_W-1:0]        cnt_ff, cnt_in;
   logic                     pend_ff, pend_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [SLACK_W-1:0]       slack_res_ff, slack_res_in;
   logic signed [PRED_W-1:0] pred_res_ff, pred_res_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SLACK_W-1:0]       rsp_slack_ff, rsp_slack_in;
   logic [AVG_W-1:0]         rsp_avg_ff, rsp_avg_in;
   logic signed [PRED_W-1:0] rsp_pred_ff, rsp_pred_in;
   logic [KIND_W-1:0]        rsp_kind_ff, rsp_kind_in;

   // combinational helpers
   logic                      req_take;
   logic                      out_free;
   logic [TIME_W:0]           t_diff;
   logic [AVG_W+1:0]          avg_sum;
   logic [AVG_W:0]            budget_diff;
   logic [SLACK_W:0]          slack_diff;
   logic [WLEN_W-1:0]         len;
   logic [AW:0]               ptr_start;
   logic                      issue;
   logic signed [PRED_W-1:0]  acc_shift;
   logic                      hist_wr;
   logic [SLACK_W-1:0]        hist_rd_data;
   mac_ctl_type               mac_ctl;
   logic signed [ACC_W-1:0]   mac_acc;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // shared wide subtract for frame time and elapsed time
   assign t_diff = (state_ff == S_FEND1) ? {1'b0, now_ff} - {1'b0, begin_ff}
                                         : {1'b0, now_ff} - {1'b0, last_end_ff};

   // running average and budget slack
   assign avg_sum     = {2'b00, avg_ff} + {1'b0, avg_ff, 1'b0} + {2'b00, ft_ff};
   assign budget_diff = {5'd0, budget_ff} - {1'b0, ft_ff};
   assign slack_diff  = {1'b0, cur_slack_ff} - elapsed_ff;

   // moving sum setup
   assign len       = (wlen_ff > WLEN_MAX) ? WLEN_MAX : wlen_ff;
   assign ptr_start = {1'b0, head_ff} - (AW+1)'({1'b0, lag_ff} + 3'd1);
   assign issue     = (cnt_ff != len);

   // rounded Q16 product sum
   assign acc_shift = PRED_W'(mac_acc >>> FRAC_W);

   // configuration writes
   always_comb begin
      budget_in = budget_ff;
      wcount_in = wcount_ff;
      wlen_in   = wlen_ff;
      weight_in = weight_ff;
      bias_in   = bias_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BUDGET:  budget_in    = csr_wdata[BUDGET_W-1:0];
            REG_WCOUNT:  wcount_in    = csr_wdata[WCOUNT_W-1:0];
            REG_WLEN:    wlen_in      = csr_wdata[WLEN_W-1:0];
            REG_WEIGHT0: weight_in[0] = $signed(csr_wdata[WEIGHT_W-1:0]);
            REG_WEIGHT1: weight_in[1] = $signed(csr_wdata[WEIGHT_W-1:0]);
            REG_WEIGHT2: weight_in[2] = $signed(csr_wdata[WEIGHT_W-1:0]);
            REG_BIAS:    bias_in      = $signed(csr_wdata[BIAS_W-1:0]);
            default: ;
         endcase
      end
   end

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      avg_in       = avg_ff;
      cur_slack_in = cur_slack_ff;
      last_end_in  = last_end_ff;
      kind_in      = kind_ff;
      begin_in     = begin_ff;
      now_in       = now_ff;
      ft_in        = ft_ff;
      elapsed_in   = elapsed_ff;
      lag_in       = lag_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      sum_in       = sum_ff;
      slack_res_in = slack_res_ff;
      pred_res_in  = pred_res_ff;
      rsp_slack_in = rsp_slack_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_pred_in  = rsp_pred_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      hist_wr      = 1'b0;
      mac_ctl      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               kind_in  = req_kind;
               begin_in = req_frame_begin_us;
               now_in   = req_now_us;
               lag_in   = '0;
               unique case (req_kind)
                  KIND_FRAME_END: state_in = S_FEND1;
                  KIND_QUERY:     state_in = S_QRY1;
                  KIND_PREDICT: begin
                     mac_ctl.clear = 1'b1;
                     state_in      = S_PSTART;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         // frame time, saturated at 24 bits, zero when the frame begins late
         S_FEND1: begin
            if (t_diff[TIME_W]) begin
               ft_in = '0;
            end else if (|t_diff[TIME_W-1:AVG_W]) begin
               ft_in = '1;
            end else begin
               ft_in = t_diff[AVG_W-1:0];
            end
            state_in = S_FEND2;
         end

         // average, slack and history push
         S_FEND2: begin
            avg_in       = (avg_ff == '0) ? ft_ff : avg_sum[AVG_W+1:2];
            cur_slack_in = budget_diff[AVG_W] ? '0 : budget_diff[SLACK_W-1:0];
            slack_res_in = cur_slack_in;
            pred_res_in  = '0;
            last_end_in  = now_ff;
            hist_wr      = 1'b1;
            head_in      = (head_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            state_in     = S_DONE;
         end

         // elapsed time, clamped above any slack value
         S_QRY1: begin
            if (t_diff[TIME_W]) begin
               elapsed_in = '0;
            end else if (|t_diff[TIME_W-1:SLACK_W]) begin
               elapsed_in = {1'b1, {SLACK_W{1'b0}}};
            end else begin
               elapsed_in = {1'b0, t_diff[SLACK_W-1:0]};
            end
            state_in = S_QRY2;
         end

         S_QRY2: begin
            slack_res_in = slack_diff[SLACK_W] ? '0 : slack_diff[SLACK_W-1:0];
            pred_res_in  = '0;
            state_in     = S_DONE;
         end

         // next lag or finish
         S_PSTART: begin
            if (lag_ff >= wcount_ff) begin
               state_in = S_PFIN;
            end else begin
               ptr_in   = ptr_start[AW] ? AW'(ptr_start + (AW+1)'(HISTORY_DEPTH))
                                        : ptr_start[AW-1:0];
               cnt_in   = '0;
               pend_in  = 1'b0;
               sum_in   = '0;
               state_in = S_PSUM;
            end
         end

         // one history read per cycle, newest first
         S_PSUM: begin
            pend_in = issue;
            if (issue) begin
               ptr_in = (ptr_ff == '0) ? AW'(HISTORY_DEPTH - 1) : ptr_ff - 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'(hist_rd_data);
            end
            if (!issue && !pend_ff) begin
               state_in = S_PMUL;
            end
         end

         S_PMUL: begin
            mac_ctl.mul = 1'b1;
            state_in    = S_PACC;
         end

         S_PACC: begin
            mac_ctl.acc = 1'b1;
            lag_in      = lag_ff + 1'b1;
            state_in    = S_PSTART;
         end

         S_PFIN: begin
            pred_res_in  = acc_shift + PRED_W'(bias_ff);
            slack_res_in = cur_slack_ff;
            state_in     = S_DONE;
         end

         // load the output register once it is free
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slack_in = slack_res_ff;
               rsp_avg_in   = avg_ff;
               rsp_pred_in  = pred_res_ff;
               rsp_kind_in  = kind_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         budget_ff    <= BUDGET_RST;
         wcount_ff    <= WCOUNT_RST;
         wlen_ff      <= WLEN_RST;
         weight_ff[0] <= WEIGHT0_RST;
         weight_ff[1] <= WEIGHT1_RST;
         weight_ff[2] <= WEIGHT2_RST;
         bias_ff      <= BIAS_RST;
         head_ff      <= '0;
         avg_ff       <= '0;
         cur_slack_ff <= '0;
         last_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         budget_ff    <= budget_in;
         wcount_ff    <= wcount_in;
         wlen_ff      <= wlen_in;
         weight_ff    <= weight_in;
         bias_ff      <= bias_in;
         head_ff      <= head_in;
         avg_ff       <= avg_in;
         cur_slack_ff <= cur_slack_in;
         last_end_ff  <= last_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      begin_ff     <= begin_in;
      now_ff       <= now_in;
      ft_ff        <= ft_in;
      elapsed_ff   <= elapsed_in;
      lag_ff       <= lag_in;
      ptr_ff       <= ptr_in;
      cnt_ff       <= cnt_in;
      pend_ff      <= pend_in;
      sum_ff       <= sum_in;
      slack_res_ff <= slack_res_in;
      pred_res_ff  <= pred_res_in;
      rsp_slack_ff <= rsp_slack_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_pred_ff  <= rsp_pred_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   // slack history
   fswp_history #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .AW            (AW)
   ) u_history (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (hist_wr),
      .wr_addr (head_ff),
      .wr_data (cur_slack_in),
      .rd_addr (ptr_ff),
      .rd_data (hist_rd_data)
   );

   // shared multiply-accumulate
   fswp_mac u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .sum    (sum_ff),
      .weight (weight_ff[lag_ff]),
      .acc    (mac_acc)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slack_us      = rsp_slack_ff;
   assign rsp_avg_frame_us  = rsp_avg_ff;
   assign rsp_prediction_us = rsp_pred_ff;
   assign rsp_echo_kind     = rsp_kind_ff;

endmodule
